@@ hw/rtl/lir_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, state encoding and control structs for the linear
// interpolation resampler. No dependencies.
package lir_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int POS_BITS    = 20;
  localparam int STEP_BITS   = 20;
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int ACC_BITS    = DIFF_BITS + POS_BITS + 1;

  localparam logic [POS_BITS-1:0]  ONE_POS  = POS_BITS'(1) << FRAC_BITS;
  localparam logic [STEP_BITS-1:0] MIN_STEP = STEP_BITS'(ONE_POS >> 4);
  localparam logic [STEP_BITS-1:0] STEP_RST = STEP_BITS'(ONE_POS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } lir_state_e;

  typedef struct packed {
    logic take_first;
    logic drop;
    logic start;
    logic emit;
  } lir_cmd_t;

  typedef struct packed {
    logic step_zero;
    logic have_prev;
    logic pos_ge_one;
    logic last;
    logic out_free;
  } lir_sts_t;

endpackage

@@ hw/rtl/linear_interp_resampler.sv @@
`timescale 1ns / 1ps
// Top level of the linear interpolation resampler: controller plus datapath.
// Depends on lir_pkg, lir_ctrl and lir_dpath.
//
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    sample_in_i
// out       output     out_valid_o / out_stall_i  sample_out_o, last_of_run_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_step_q16_i
//
// An input beat that yields results stalls the input until its run is done; a
// beat that yields none does not. Unless the output stalls, one result leaves
// per cycle, set by the single accumulate-and-add stage that advances the
// interpolation product by a precomputed difference times step.
// Reset sets the step to 1.0 and clears the history and read position.
// A stall on the output holds the output register and pauses the run.
module linear_interp_resampler import lir_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          last_of_run_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [STEP_BITS-1:0]          cfg_step_q16_i
);

  lir_cmd_t cmd;
  lir_sts_t sts;

  assign cfg_ready_o = 1'b1;

  lir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lir_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_step_q16_i (cfg_step_q16_i),
    .sample_in_i    (sample_in_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .sample_out_o   (sample_out_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

@@ hw/rtl/lir_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine of the resampler: input handshake and sequencing
// of the output run. Depends on lir_pkg.
module lir_ctrl import lir_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lir_sts_t sts_i,
  output lir_cmd_t cmd_o
);

  lir_state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !sts_i.step_zero) begin
          if (!sts_i.have_prev) begin
            cmd_o.take_first = 1'b1;
          end else if (sts_i.pos_ge_one) begin
            cmd_o.drop = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/lir_dpath.sv @@
`timescale 1ns / 1ps
// Datapath of the resampler: step register, sample history, read position,
// incremental interpolation product and the output register. Depends on lir_pkg.
module lir_dpath import lir_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [STEP_BITS-1:0]          cfg_step_q16_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  lir_cmd_t                      cmd_i,
  output lir_sts_t                      sts_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          last_of_run_o
);

  logic [STEP_BITS-1:0]          step_q;
  logic                          have_q;
  logic [POS_BITS-1:0]           pos_q, pos_d;
  logic signed [SAMPLE_BITS-1:0] prev_q, x_q;
  logic signed [ACC_BITS-1:0]    acc_q, dstep_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_last_q;

  logic [STEP_BITS-1:0]          step_eff;
  logic signed [DIFF_BITS-1:0]   diff;
  logic signed [ACC_BITS-1:0]    acc_init, dstep_init;
  logic [POS_BITS:0]             pos_sum;
  logic                          next_last;
  logic signed [SAMPLE_BITS-1:0] interp;

  always_comb begin
    if (step_q == '0) begin
      step_eff = '0;
    end else if (step_q < MIN_STEP) begin
      step_eff = MIN_STEP;
    end else begin
      step_eff = step_q;
    end
  end

  assign diff = $signed({sample_in_i[SAMPLE_BITS-1], sample_in_i})
              - $signed({prev_q[SAMPLE_BITS-1], prev_q});
  assign acc_init   = ACC_BITS'(diff) * ACC_BITS'($signed({1'b0, pos_q}));
  assign dstep_init = ACC_BITS'(diff) * ACC_BITS'($signed({1'b0, step_eff}));

  assign pos_sum   = {1'b0, pos_q} + {1'b0, step_eff};
  assign next_last = (pos_sum >= {1'b0, ONE_POS});
  assign interp    = prev_q + $signed(acc_q[FRAC_BITS +: SAMPLE_BITS]);

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.drop) begin
      pos_d = pos_q - ONE_POS;
    end else if (cmd_i.emit) begin
      pos_d = next_last ? POS_BITS'(pos_sum - {1'b0, ONE_POS}) : pos_sum[POS_BITS-1:0];
    end
  end

  assign sts_o.step_zero  = (step_q == '0);
  assign sts_o.have_prev  = have_q;
  assign sts_o.pos_ge_one = (pos_q >= ONE_POS);
  assign sts_o.last       = next_last;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_RST;
      have_q      <= 1'b0;
      pos_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        step_q <= cfg_step_q16_i;
      end
      pos_q <= pos_d;
      if (cmd_i.take_first) begin
        prev_q <= sample_in_i;
        have_q <= 1'b1;
      end else if (cmd_i.drop) begin
        prev_q <= sample_in_i;
      end else if (cmd_i.emit && next_last) begin
        prev_q <= x_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q     <= sample_in_i;
      acc_q   <= acc_init;
      dstep_q <= dstep_init;
    end else if (cmd_i.emit) begin
      acc_q <= acc_q + dstep_q;
    end
    if (cmd_i.emit) begin
      out_sample_q <= interp;
      out_last_q   <= next_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_sample_q;
  assign last_of_run_o = out_last_q;

endmodule

@@ hw/rtl/lir_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the resampler, bound to the top level.
// Depends on lir_pkg and linear_interp_resampler.
module lir_checker import lir_pkg::*; (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] sample_out_o,
  input logic                          last_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(sample_out_o) && $stable(last_of_run_o))
    else $error("Stalled output beat changed.");

  a_no_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("Result appeared one cycle after an input beat.");

  a_run_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> in_stall_o)
    else $error("Input taken while a run is unfinished.");

  a_run_ends_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o && last_of_run_o)
    else $error("Run ended without a last beat.");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .sample_out_o  (sample_out_o),
  .last_of_run_o (last_of_run_o)
);
